[hdl/lr_pkg.sv]
// shared constants and types for the line rasterizer
package lr_pkg;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // pixel colour width
  localparam int unsigned COLOR_BITS = 32;

  // item kind carried in the slave tuser bit
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_e;

endpackage

[hdl/line_rasterizer.sv]
// line rasterizer: bresenham style line walk, one pixel per step transaction on an active line
//
//  channel  | direction | tdata (low bit up)                          | side band
//  ---------+-----------+---------------------------------------------+------------------------
//  s_axis   | in        | start_x, start_y, end_x, end_y, line_color  | tuser: action
//  m_axis   | out       | pixel_x, pixel_y, pixel_color               | tlast: last_pixel
//
//  one transaction is taken every cycle while m_axis is not stalled; a step transaction goes
//  into the input register, and its pixel is then loaded into the pixel register that drives m_axis
//  rst_ni clears the input and pixel valid flags and the line state (idle, no line)
//  a stall on m_axis holds the pixel register and then the input register; the input
//  register frees up in the same cycle the pending pixel is taken
module line_rasterizer #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                                   s_axis_tvalid,
  output logic                                                   s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color, zero pad
  input  logic [((4*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // action
  input  logic                                                   s_axis_tuser,

  output logic                                                   m_axis_tvalid,
  input  logic                                                   m_axis_tready,
  // pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*COORD_BITS+lr_pkg::COLOR_BITS+7)/8)*8-1:0]  m_axis_tdata,
  // last_pixel
  output logic                                                   m_axis_tlast
);
  import lr_pkg::*;

  localparam int unsigned W        = COORD_BITS;
  localparam int unsigned OutDataW = ((2*W + COLOR_BITS + 7) / 8) * 8;

  // input register
  logic                  s1_valid_q, s1_valid_d;
  action_e               s1_act_q;
  logic signed [W-1:0]   s1_x0_q, s1_y0_q, s1_x1_q, s1_y1_q;
  logic [COLOR_BITS-1:0] s1_color_q;

  // line state
  logic                  busy_q, busy_d;
  logic                  steep_q, steep_d;
  logic signed [W-1:0]   cur_major_q, cur_major_d;
  logic signed [W-1:0]   cur_minor_q, cur_minor_d;
  logic signed [W-1:0]   stop_major_q, stop_major_d;
  logic signed [1:0]     minor_dir_q, minor_dir_d;
  logic [W+1:0]          err_acc_q, err_acc_d;
  logic [W:0]            err_limit_q, err_limit_d;
  logic [W:0]            err_inc_q, err_inc_d;
  logic [COLOR_BITS-1:0] held_color_q, held_color_d;

  // pixel register
  logic                  out_valid_q, out_valid_d;
  logic signed [W-1:0]   out_x_q, out_x_d;
  logic signed [W-1:0]   out_y_q, out_y_d;
  logic [COLOR_BITS-1:0] out_color_q, out_color_d;
  logic                  out_last_q, out_last_d;

  logic adv;       // stage can move this cycle
  logic s_accept;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d = s_accept ? 1'b1 : (adv ? 1'b0 : s1_valid_q);

  // start setup: differences, axis choice, endpoint order
  logic signed [W:0]   dx_s, dy_s;
  logic [W:0]          dx_abs, dy_abs;
  logic [W-1:0]        dx, dy, dmaj, dmin;
  logic                st_steep, st_swap;
  logic signed [W-1:0] a_maj, a_min, b_maj, b_min;
  logic signed [W-1:0] first_maj, first_min, last_maj, last_min;
  logic [W:0]          st_limit, st_inc;

  // step: error update
  logic [W+1:0]        err_sum;
  logic                minor_move;
  logic                at_last;

  always_comb begin
    dx_s   = {s1_x1_q[W-1], s1_x1_q} - {s1_x0_q[W-1], s1_x0_q};
    dy_s   = {s1_y1_q[W-1], s1_y1_q} - {s1_y0_q[W-1], s1_y0_q};
    dx_abs = dx_s[W] ? (~dx_s + 1'b1) : dx_s;
    dy_abs = dy_s[W] ? (~dy_s + 1'b1) : dy_s;
    dx     = dx_abs[W-1:0];
    dy     = dy_abs[W-1:0];

    st_steep = dy > dx;
    if (st_steep) begin
      a_maj = s1_y0_q; a_min = s1_x0_q; b_maj = s1_y1_q; b_min = s1_x1_q;
      dmaj  = dy;      dmin  = dx;
    end else begin
      a_maj = s1_x0_q; a_min = s1_y0_q; b_maj = s1_x1_q; b_min = s1_y1_q;
      dmaj  = dx;      dmin  = dy;
    end
    st_swap   = a_maj > b_maj;
    first_maj = st_swap ? b_maj : a_maj;
    first_min = st_swap ? b_min : a_min;
    last_maj  = st_swap ? a_maj : b_maj;
    last_min  = st_swap ? a_min : b_min;
    st_limit  = {1'b0, dmaj} + 1'b1;
    st_inc    = {1'b0, dmin} + 1'b1;

    err_sum    = err_acc_q + {1'b0, err_inc_q};
    minor_move = err_sum >= {1'b0, err_limit_q};
    at_last    = cur_major_q == stop_major_q;
  end

  always_comb begin
    busy_d       = busy_q;
    steep_d      = steep_q;
    cur_major_d  = cur_major_q;
    cur_minor_d  = cur_minor_q;
    stop_major_d = stop_major_q;
    minor_dir_d  = minor_dir_q;
    err_acc_d    = err_acc_q;
    err_limit_d  = err_limit_q;
    err_inc_d    = err_inc_q;
    held_color_d = held_color_q;

    out_valid_d = adv ? 1'b0 : out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;

    if (adv && s1_valid_q) begin
      case (s1_act_q)
        ACT_START: begin
          // a new line replaces whatever is being walked
          busy_d       = 1'b1;
          steep_d      = st_steep;
          cur_major_d  = first_maj;
          cur_minor_d  = first_min;
          stop_major_d = last_maj;
          if (last_min > first_min)      minor_dir_d = 2'sb01;
          else if (last_min < first_min) minor_dir_d = 2'sb11;
          else                           minor_dir_d = 2'sb00;
          err_limit_d  = st_limit;
          err_inc_d    = st_inc;
          err_acc_d    = {2'b00, st_inc[W:1]};
          held_color_d = s1_color_q;
        end
        ACT_STEP: begin
          // a step while idle is dropped
          if (busy_q) begin
            out_valid_d = 1'b1;
            out_x_d     = steep_q ? cur_minor_q : cur_major_q;
            out_y_d     = steep_q ? cur_major_q : cur_minor_q;
            out_color_d = held_color_q;
            out_last_d  = at_last;
            if (minor_move) begin
              cur_minor_d = cur_minor_q + W'(minor_dir_q);
              err_acc_d   = err_sum - {1'b0, err_limit_q};
            end else begin
              err_acc_d   = err_sum;
            end
            if (at_last) busy_d = 1'b0;
            else         cur_major_d = cur_major_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      busy_q       <= 1'b0;
      steep_q      <= 1'b0;
      cur_major_q  <= '0;
      cur_minor_q  <= '0;
      stop_major_q <= '0;
      minor_dir_q  <= '0;
      err_acc_q    <= '0;
      err_limit_q  <= '0;
      err_inc_q    <= '0;
      held_color_q <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      busy_q       <= busy_d;
      steep_q      <= steep_d;
      cur_major_q  <= cur_major_d;
      cur_minor_q  <= cur_minor_d;
      stop_major_q <= stop_major_d;
      minor_dir_q  <= minor_dir_d;
      err_acc_q    <= err_acc_d;
      err_limit_q  <= err_limit_d;
      err_inc_q    <= err_inc_d;
      held_color_q <= held_color_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_act_q   <= action_e'(s_axis_tuser);
      s1_x0_q    <= s_axis_tdata[W-1:0];
      s1_y0_q    <= s_axis_tdata[2*W-1:W];
      s1_x1_q    <= s_axis_tdata[3*W-1:2*W];
      s1_y1_q    <= s_axis_tdata[4*W-1:3*W];
      s1_color_q <= s_axis_tdata[4*W+COLOR_BITS-1:4*W];
    end
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // error term stays below its limit while a line is walked
  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (err_acc_q < {1'b0, err_limit_q}))
    else $error("error term reached its limit");

  // the walk never passes the far endpoint
  a_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cur_major_q <= stop_major_q))
    else $error("major coordinate passed the endpoint");

  // a pixel only comes from a step taken while busy
  a_pixel_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      $past(adv && s1_valid_q && (s1_act_q == ACT_STEP) && busy_q))
    else $error("pixel without a step on an active line");

  // a step on the final pixel ends the line
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && (s1_act_q == ACT_STEP) && busy_q && at_last) |=> !busy_q)
    else $error("line still active after its last pixel");
`endif

endmodule

[tb/tb.sv]
// testbench for line_rasterizer: directed lines, then random line walks checked by a predictor
`timescale 1ns / 1ps

module tb;

  import lr_pkg::*;

  localparam int CB           = COORD_BITS_DEF;
  localparam int S_W          = ((4*CB+COLOR_BITS+7)/8)*8;
  localparam int M_W          = ((2*CB+COLOR_BITS+7)/8)*8;
  localparam int COORD_LO     = -(1 << (CB-1));
  localparam int COORD_HI     = (1 << (CB-1)) - 1;
  localparam int ITEM_TARGET  = 1600;
  localparam int HOLD_AT      = 500;
  localparam int QUIET_AT     = 1350;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 400000;

  typedef logic signed [CB-1:0] coord_t;

  // one slave transaction: kind in tuser, endpoints and colour in tdata
  typedef struct packed {
    action_e                 act;
    coord_t                  x0;
    coord_t                  y0;
    coord_t                  x1;
    coord_t                  y1;
    logic [COLOR_BITS-1:0]   color;
  } item_t;

  // one master transaction
  typedef struct packed {
    coord_t                  x;
    coord_t                  y;
    logic [COLOR_BITS-1:0]   color;
    logic                    last;
  } pixel_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_NONE,   // no pixel may come from this row
    CHK_PIXEL,  // pixel typed into the row
    CHK_MODEL   // pixel from the predictor
  } chk_e;

  typedef struct {
    item_t  it;
    chk_e   chk;
    pixel_t px;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata = '0;
  logic           s_axis_tuser = ACT_START;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [M_W-1:0] m_axis_tdata;
  logic           m_axis_tlast;

  line_rasterizer #(
    .COORD_BITS(CB)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // line walk state kept by the predictor, widths as in the block
  bit                  busy_q;
  bit                  steep_q;
  coord_t              maj_q;
  coord_t              min_q;
  coord_t              stop_q;
  logic signed [1:0]   dir_q;
  bit [CB+1:0]         err_q;
  bit [CB:0]           lim_q;
  bit [CB:0]           inc_q;
  logic [COLOR_BITS-1:0] color_q;

  pixel_t pending_pixels[$];
  int     items_taken = 0;
  int     mismatches = 0;
  int unsigned cycles = 0;

  // idling controls shared by the sender and the receiver
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_fired = 1'b0;

  // predictor: apply one accepted item, return 1 when it yields a pixel
  function automatic bit rasterize_item(input item_t it, output pixel_t px);
    int dx, dy, amaj, amin, bmaj, bmin, dmaj, dmin, t, acc;
    bit last;
    px = '0;
    if (it.act == ACT_START) begin
      dx = int'(it.x1) - int'(it.x0);
      dy = int'(it.y1) - int'(it.y0);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      // ties go to x as the major axis
      steep_q = dy > dx;
      if (steep_q) begin
        amaj = it.y0; amin = it.x0; bmaj = it.y1; bmin = it.x1;
        dmaj = dy;    dmin = dx;
      end else begin
        amaj = it.x0; amin = it.y0; bmaj = it.x1; bmin = it.y1;
        dmaj = dx;    dmin = dy;
      end
      // walk always runs toward the larger major coordinate
      if (amaj > bmaj) begin
        t = amaj; amaj = bmaj; bmaj = t;
        t = amin; amin = bmin; bmin = t;
      end
      maj_q   = coord_t'(amaj);
      min_q   = coord_t'(amin);
      stop_q  = coord_t'(bmaj);
      dir_q   = (bmin > amin) ? 2'sb01 : ((bmin < amin) ? 2'sb11 : 2'sb00);
      lim_q   = (CB+1)'(dmaj + 1);
      inc_q   = (CB+1)'(dmin + 1);
      err_q   = (CB+2)'(inc_q >> 1);
      color_q = it.color;
      busy_q  = 1'b1;
      return 1'b0;
    end
    // step while idle is dropped
    if (!busy_q) return 1'b0;
    last     = (maj_q == stop_q);
    px.x     = steep_q ? min_q : maj_q;
    px.y     = steep_q ? maj_q : min_q;
    px.color = color_q;
    px.last  = last;
    acc = int'(err_q) + int'(inc_q);
    if (acc >= int'(lim_q)) begin
      min_q = coord_t'(int'(min_q) + int'(dir_q));
      acc   = acc - int'(lim_q);
    end
    err_q = (CB+2)'(acc);
    if (last) busy_q = 1'b0;
    else      maj_q  = coord_t'(int'(maj_q) + 1);
    return 1'b1;
  endfunction

  function automatic item_t mk_step();
    item_t it;
    it.act   = ACT_STEP;
    it.x0    = coord_t'($urandom);
    it.y0    = coord_t'($urandom);
    it.x1    = coord_t'($urandom);
    it.y1    = coord_t'($urandom);
    it.color = $urandom;
    return it;
  endfunction

  function automatic item_t mk_start(input int x0, input int y0, input int x1, input int y1,
                                     input logic [COLOR_BITS-1:0] color);
    item_t it;
    it.act   = ACT_START;
    it.x0    = coord_t'(x0);
    it.y0    = coord_t'(y0);
    it.x1    = coord_t'(x1);
    it.y1    = coord_t'(y1);
    it.color = color;
    return it;
  endfunction

  function automatic pixel_t mk_pixel(input int x, input int y,
                                      input logic [COLOR_BITS-1:0] color, input bit last);
    pixel_t px;
    px.x     = coord_t'(x);
    px.y     = coord_t'(y);
    px.color = color;
    px.last  = last;
    return px;
  endfunction

  // endpoint offset from a base, mirrored when it would leave the coordinate range
  function automatic int nudge(input int base, input int delta);
    if (base + delta > COORD_HI || base + delta < COORD_LO) return base - delta;
    return base + delta;
  endfunction

  // start item for a short line anywhere in the plane, with axis and diagonal cases
  function automatic item_t rand_line(input int span);
    int x0, y0, dx, dy;
    x0 = int'($urandom_range(0, (1 << CB) - 1)) + COORD_LO;
    y0 = int'($urandom_range(0, (1 << CB) - 1)) + COORD_LO;
    dx = int'($urandom_range(0, 2*span)) - span;
    dy = int'($urandom_range(0, 2*span)) - span;
    case ($urandom_range(0, 7))
      0: dy = 0;
      1: dx = 0;
      2: dy = $urandom_range(0, 1) ? dx : -dx;
      default: ;
    endcase
    return mk_start(x0, y0, nudge(x0, dx), nudge(y0, dy), $urandom);
  endfunction

  // offer one item, wait for its transaction, then book the expected pixel
  task automatic send_item(input item_t it, input chk_e chk, input pixel_t typed);
    pixel_t px;
    bit made;
    if (!quiet && tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.act;
    s_axis_tdata  <= S_W'({it.color, it.y1, it.x1, it.y0, it.x0});
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.act == ACT_START || busy_q) items_taken++;
    made = rasterize_item(it, px);
    case (chk)
      CHK_MODEL: if (made) pending_pixels.push_back(px);
      CHK_PIXEL: pending_pixels.push_back(typed);
      default: ;
    endcase
  endtask

  // stimulus: directed rows, random line walks, then drain
  initial begin
    row_t dir_rows[$];
    int   sel;
    int   span;
    item_t it;

    // step while idle, then a single point line
    dir_rows.push_back('{mk_step(), CHK_NONE, '0});
    dir_rows.push_back('{mk_start(100, -5, 100, -5, 32'hDEADBEEF), CHK_NONE, '0});
    dir_rows.push_back('{mk_step(), CHK_PIXEL, mk_pixel(100, -5, 32'hDEADBEEF, 1'b1)});
    dir_rows.push_back('{mk_step(), CHK_NONE, '0});
    // full range diagonal, equal differences so x is major
    dir_rows.push_back('{mk_start(COORD_LO, COORD_LO, COORD_HI, COORD_HI, 32'hFFFFFFFF),
                         CHK_NONE, '0});
    dir_rows.push_back('{mk_step(), CHK_PIXEL,
                         mk_pixel(COORD_LO, COORD_LO, 32'hFFFFFFFF, 1'b0)});
    dir_rows.push_back('{mk_step(), CHK_PIXEL,
                         mk_pixel(COORD_LO + 1, COORD_LO + 1, 32'hFFFFFFFF, 1'b0)});
    // start while busy, reversed horizontal line with no minor movement
    dir_rows.push_back('{mk_start(5, 0, 0, 0, 32'h00000000), CHK_NONE, '0});
    repeat (6) dir_rows.push_back('{mk_step(), CHK_MODEL, '0});
    // steep line given from high y to low y, swapped endpoints so it is walked upward in y
    dir_rows.push_back('{mk_start(0, 3, 1, -2, 32'h12345678), CHK_NONE, '0});
    repeat (6) dir_rows.push_back('{mk_step(), CHK_MODEL, '0});
    dir_rows.push_back('{mk_step(), CHK_NONE, '0});
    // extreme x endpoints, swapped, negative minor direction
    dir_rows.push_back('{mk_start(COORD_HI, 0, COORD_LO, 1, 32'hA5A5A5A5), CHK_NONE, '0});
    dir_rows.push_back('{mk_step(), CHK_PIXEL, mk_pixel(COORD_LO, 1, 32'hA5A5A5A5, 1'b0)});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].px);

    while (items_taken < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) tx_idle_on = $urandom_range(0, 1);
      if ($urandom_range(0, 15) == 0) rx_idle_on = $urandom_range(0, 1);
      // one long receiver hold-off so the pipeline backs up into the input
      if (items_taken >= HOLD_AT && !hold_fired) begin
        hold_fired = 1'b1;
        hold_req   = 1'b1;
      end
      if (items_taken >= QUIET_AT) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // complete line walk, mostly short
        span = ($urandom_range(0, 19) == 0) ? 300 : ($urandom_range(0, 1) ? 4 : 24);
        send_item(rand_line(span), CHK_MODEL, '0);
        while (busy_q) send_item(mk_step(), CHK_MODEL, '0);
        if ($urandom_range(0, 3) == 0) send_item(mk_step(), CHK_MODEL, '0);
      end else if (sel < 85) begin
        // arbitrary endpoints, walked partway then abandoned
        it = mk_step();
        it.act = ACT_START;
        send_item(it, CHK_MODEL, '0);
        repeat ($urandom_range(0, 30)) send_item(mk_step(), CHK_MODEL, '0);
      end else if (sel < 95) begin
        repeat ($urandom_range(1, 4)) send_item(mk_step(), CHK_MODEL, '0);
      end else begin
        // start with no steps of its own
        send_item(rand_line(4), CHK_MODEL, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random ready bursts, one long hold-off, steady ready at the end
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && rx_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // pixel checker: each master transaction against the oldest expected pixel
  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x     = m_axis_tdata[CB-1:0];
      got.y     = m_axis_tdata[2*CB-1:CB];
      got.color = m_axis_tdata[2*CB+COLOR_BITS-1:2*CB];
      got.last  = m_axis_tlast;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b",
                 $time, got.x, got.y, got.color, got.last);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t: pixel mismatch expected x=%0d y=%0d color=%h last=%b",
                   $time, want.x, want.y, want.color, want.last);
          $display("%0t:                  actual x=%0d y=%0d color=%h last=%b",
                   $time, got.x, got.y, got.color, got.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
